[hw/rtl/ira_pkg.sv]
// Package for the interval room allocator: request word type, queue sizing,
// default room count. No dependencies.
`timescale 1ns / 1ps

package ira_pkg;

  localparam int ROOM_COUNT_DEFAULT = 64;

  localparam int TIME_W = 32;
  localparam int ID_W   = 16;
  localparam int ROOM_W = 7;

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [TIME_W-1:0] arrival_time;
    logic [TIME_W-1:0] departure_time;
    logic [ID_W-1:0]   customer_id;
  } req_t;

  // Head of the request queue as seen by the back part
  typedef struct packed {
    logic valid;
    req_t req;
  } queue_head_t;

endpackage

[hw/rtl/ira_if.sv]
// Channel interfaces of the interval room allocator: request and result words.
// Depends on ira_pkg.
`timescale 1ns / 1ps

interface ira_req_if;
  logic                        valid;
  logic                        ready;
  logic [ira_pkg::TIME_W-1:0]  arrival_time;
  logic [ira_pkg::TIME_W-1:0]  departure_time;
  logic [ira_pkg::ID_W-1:0]    customer_id;

  modport source (output valid, arrival_time, departure_time, customer_id, input ready);
  modport sink   (input valid, arrival_time, departure_time, customer_id, output ready);
endinterface

interface ira_res_if;
  logic                        valid;
  logic                        ready;
  logic [ira_pkg::ID_W-1:0]    result_id;
  logic [ira_pkg::ROOM_W-1:0]  room_number;
  logic [ira_pkg::ROOM_W-1:0]  rooms_opened;
  logic                        overflow;

  modport source (output valid, result_id, room_number, rooms_opened, overflow, input ready);
  modport sink   (input valid, result_id, room_number, rooms_opened, overflow, output ready);
endinterface

[hw/rtl/ira_front.sv]
// Front part: accepts request words into a short queue for the back part.
// Depends on ira_pkg and ira_if.
`timescale 1ns / 1ps

module ira_front (
  input  logic                 clk,
  input  logic                 rst,
  ira_req_if.sink              req,
  output ira_pkg::queue_head_t head,
  input  logic                 pop
);

  ira_pkg::req_t                   slots [ira_pkg::QUEUE_DEPTH];
  logic [ira_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [ira_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [ira_pkg::QUEUE_CNT_W-1:0] count;
  logic                            push;
  logic                            do_pop;

  assign req.ready = (count != ira_pkg::QUEUE_CNT_W'(ira_pkg::QUEUE_DEPTH));
  assign push      = req.valid && req.ready;
  assign do_pop    = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.req   = slots[rd_ptr];

  function automatic logic [ira_pkg::QUEUE_PTR_W-1:0] wrap_inc(
    input logic [ira_pkg::QUEUE_PTR_W-1:0] p
  );
    if (p == ira_pkg::QUEUE_PTR_W'(ira_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + ira_pkg::QUEUE_PTR_W'(1);
  endfunction

  // Payload slots, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{arrival_time:   req.arrival_time,
                         departure_time: req.departure_time,
                         customer_id:    req.customer_id};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      case ({push, do_pop})
        2'b10:   count <= count + ira_pkg::QUEUE_CNT_W'(1);
        2'b01:   count <= count - ira_pkg::QUEUE_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[hw/rtl/ira_back.sv]
// Back part: scans the room departure memory for one request, assigns a room
// and holds the result word. Depends on ira_pkg and ira_if.
`timescale 1ns / 1ps

module ira_back #(
  parameter int ROOM_COUNT = ira_pkg::ROOM_COUNT_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ira_pkg::queue_head_t head,
  output logic                 pop,
  ira_res_if.source            res
);

  localparam int IDX_W = $clog2(ROOM_COUNT);
  localparam int CNT_W = $clog2(ROOM_COUNT + 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t                      state;
  ira_pkg::req_t               cur;
  logic [CNT_W-1:0]            open_count;
  logic [CNT_W-1:0]            issue_idx;
  logic                        issuing;
  logic                        cmp_valid;
  logic [IDX_W-1:0]            cmp_idx;
  logic [ira_pkg::TIME_W-1:0]  rd_data;
  logic                        found;
  logic [IDX_W-1:0]            best_idx;
  logic [ira_pkg::TIME_W-1:0]  best_dep;
  logic                        hit;
  logic                        out_valid;
  logic                        out_free;
  logic                        load_out;
  logic                        can_open;
  logic                        mem_we;
  logic [IDX_W-1:0]            mem_waddr;
  logic [CNT_W-1:0]            room_sel;
  logic [CNT_W-1:0]            open_count_next;

  logic [ira_pkg::TIME_W-1:0]  mem [ROOM_COUNT];

  assign pop      = (state == ST_IDLE) && head.valid;
  assign issuing  = (state == ST_SCAN) && (issue_idx < open_count);
  assign hit      = cmp_valid && (rd_data < cur.arrival_time) &&
                    (!found || (rd_data >= best_dep));
  assign out_free = !out_valid || res.ready;
  assign load_out = (state == ST_FINISH) && out_free;
  assign can_open = (open_count < CNT_W'(ROOM_COUNT));
  assign mem_we   = load_out && (found || can_open);
  assign mem_waddr = found ? best_idx : open_count[IDX_W-1:0];

  always_comb begin
    open_count_next = open_count;
    if (found) begin
      room_sel = CNT_W'(best_idx) + CNT_W'(1);
    end else if (can_open) begin
      open_count_next = open_count + CNT_W'(1);
      room_sel        = open_count + CNT_W'(1);
    end else begin
      room_sel = '0;
    end
  end

  // Departure memory: one read port for the scan, one write port at finish
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= cur.departure_time;
    end
    if (issuing) begin
      rd_data <= mem[issue_idx[IDX_W-1:0]];
    end
  end

  // Working payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head.req;
    end
    cmp_idx <= issue_idx[IDX_W-1:0];
    if (hit) begin
      best_idx <= cmp_idx;
      best_dep <= rd_data;
    end
    if (load_out) begin
      res.result_id    <= cur.customer_id;
      res.room_number  <= ira_pkg::ROOM_W'(room_sel);
      res.rooms_opened <= ira_pkg::ROOM_W'(open_count_next);
      res.overflow     <= !found && !can_open;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      open_count <= '0;
      issue_idx  <= '0;
      cmp_valid  <= 1'b0;
      found      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // Load a new result word, or drop the held one once it is taken
      out_valid <= load_out || (out_valid && !res.ready);
      case (state)
        ST_IDLE: begin
          if (head.valid) begin
            found     <= 1'b0;
            issue_idx <= '0;
            cmp_valid <= 1'b0;
            state     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          cmp_valid <= issuing;
          if (issuing) begin
            issue_idx <= issue_idx + CNT_W'(1);
          end
          if (hit) begin
            found <= 1'b1;
          end
          if (!issuing && !cmp_valid) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            open_count <= open_count_next;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign res.valid = out_valid;

  a_open_bounded: assert property (@(posedge clk) disable iff (rst)
    open_count <= CNT_W'(ROOM_COUNT))
    else $error("open room count beyond room count");

  a_scan_in_open: assert property (@(posedge clk) disable iff (rst)
    issuing |-> (issue_idx < CNT_W'(ROOM_COUNT)))
    else $error("scan reads beyond the room memory");

  a_best_opened: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && found) |-> (CNT_W'(best_idx) < open_count))
    else $error("chosen room was never opened");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FINISH))
    else $error("result word raised outside finish");

  a_overflow_room_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.overflow) |-> (res.room_number == '0))
    else $error("overflow result carries a room");

endmodule

[hw/rtl/interval_room_allocator.sv]
// Interval room allocator: a queue front end feeding a room scan back end.
// Each request passes from the queue head to the back part, which scans the open
// rooms and then loads the result word; the back part takes no new request until
// it has loaded the result word of the last one. The scan uses the single read
// port of the departure memory and reads one room per cycle.
// Reset: rst (synchronous) empties the queue, zeroes the open room count and
// drops any held result; the departure memory is not cleared.
`timescale 1ns / 1ps

module interval_room_allocator #(
  parameter int ROOM_COUNT = ira_pkg::ROOM_COUNT_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  ira_req_if.sink   req,
  ira_res_if.source res
);

  // Head of the request queue and the pop strobe from the back part
  ira_pkg::queue_head_t head;
  logic                 pop;

  // Front: accept request words while the queue has room, even when a
  // result word is still waiting downstream.
  ira_front u_front (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .head (head),
    .pop  (pop)
  );

  // Back: take one request, walk the departure of every open room, pick
  // the latest departure strictly below the arrival (higher room on ties),
  // open a new room when none qualifies, flag overflow when all are busy,
  // then hold the result word until the sink takes it.
  ira_back #(
    .ROOM_COUNT (ROOM_COUNT)
  ) u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .res  (res)
  );

endmodule
